/* sv/timed_command_wheel_top_assert.svh */
// ----------------------------------------------------------------------------
// Timed command wheel assertion macros
// Same-cycle and next-cycle implication checks on clk, gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef TIMED_COMMAND_WHEEL_TOP_ASSERT_SVH
`define TIMED_COMMAND_WHEEL_TOP_ASSERT_SVH

// check post in the same cycle as pre
`define TCW_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("timed command wheel check failed");

// check post in the cycle after pre
`define TCW_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("timed command wheel check failed");

`endif

/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Timed command wheel package
// Word types, result codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

	localparam logic CMD_SCHED = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FAR   = 2'd1;
	localparam logic [1:0] ST_VOICE = 2'd2;

	localparam int LANE_W = 8;
	localparam int LAG_W  = 10;
	localparam int TICK_W = 32;
	localparam int DUE_W  = 32;
	localparam logic [LAG_W-1:0] LAG_RESET = 10'd16;

	typedef struct packed {
		logic              command;
		logic [2:0]        voice;
		logic [LANE_W-1:0] voice_code;
		logic [TICK_W-1:0] target_tick;
		logic [TICK_W-1:0] now_tick;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [DUE_W-1:0] due_codes;
		logic             any_due;
	} out_word_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic calc;
		logic check;
		logic sched_wr;
		logic walk;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sched_ok;
		logic walk_done;
	} dp_stat_t;

endpackage

/* sv/tcw_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// Timed command wheel controller
// Sequences reset clearing, schedule read-modify-write and drain walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             command,
	output logic             busy,
	output tcw_pkg::ctl_cmd_t cmd,
	input  tcw_pkg::dp_stat_t stat
);

	import tcw_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_CALC  = 6'b000100,
		S_CHECK = 6'b001000,
		S_WRITE = 6'b010000,
		S_WALK  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = (command == CMD_DRAIN) ? S_WALK : S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nxt = stat.sched_ok ? S_WRITE : S_IDLE;
			end
			S_WRITE: begin
				cmd.sched_wr = 1'b1;
				state_nxt = S_IDLE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* sv/tcw_dp.sv */
// ----------------------------------------------------------------------------
// Timed command wheel datapath
// Slot memory, tick arithmetic, drain pointer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_dp #(
	parameter int SLOT_BITS = 10,
	parameter int VOICES    = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::in_word_t           item,
	input  logic                        lag_we,
	input  logic [tcw_pkg::LAG_W-1:0]   lag_wdata,
	input  tcw_pkg::ctl_cmd_t           cmd,
	output tcw_pkg::dp_stat_t           stat,
	output tcw_pkg::out_word_t          result,
	output logic                        done
);

	import tcw_pkg::*;

	localparam int SLOTS  = 1 << SLOT_BITS;
	localparam int WORD_W = LANE_W * VOICES;
	localparam int LIM_W  = SLOT_BITS + 1;

	// control state
	logic [LAG_W-1:0]     lag_q;
	logic [SLOT_BITS-1:0] dpos_q;
	logic [SLOT_BITS-1:0] clr_cnt_q;
	logic                 rd_pend_q;
	logic                 done_q;

	// payload
	in_word_t             item_q;
	logic [SLOT_BITS-1:0] end_q;
	logic [SLOT_BITS-1:0] pend_addr_q;
	logic [SLOT_BITS-1:0] t_slot_q;
	logic [TICK_W-1:0]    ahead_q;
	logic [LIM_W-1:0]     limit_q;
	logic                 lim_neg_q;
	logic [WORD_W-1:0]    latest_q;
	logic                 any_q;
	out_word_t            res_q;

	logic [TICK_W-1:0]    lag32;
	logic [TICK_W-1:0]    slots32;
	logic [TICK_W-1:0]    t_max;
	logic                 voice_bad;
	logic                 too_far;
	logic [SLOT_BITS-1:0] dpos_inc;
	logic [WORD_W-1:0]    rdata;
	logic [WORD_W-1:0]    merged;
	logic                 ram_we;
	logic [SLOT_BITS-1:0] ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;
	logic [SLOT_BITS-1:0] ram_raddr;

	assign lag32     = TICK_W'(lag_q);
	assign slots32   = TICK_W'(SLOTS);
	assign t_max     = (item_q.target_tick > item_q.now_tick) ?
		item_q.target_tick : item_q.now_tick;
	assign voice_bad = ({1'b0, item_q.voice} >= 4'(VOICES));
	assign too_far   = lim_neg_q || (ahead_q > TICK_W'(limit_q));
	assign dpos_inc  = dpos_q + SLOT_BITS'(1);

	assign stat.clr_last  = (clr_cnt_q == {SLOT_BITS{1'b1}});
	assign stat.sched_ok  = !voice_bad && !too_far;
	assign stat.walk_done = (dpos_q == end_q) && !rd_pend_q;

	always_comb begin
		merged = rdata;
		for (int v = 0; v < VOICES; v++) begin
			if (item_q.voice == 3'(v)) begin
				merged[v*LANE_W +: LANE_W] = item_q.voice_code;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_addr_q;
		ram_wdata = '0;
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end else if (cmd.sched_wr) begin
			ram_we    = 1'b1;
			ram_waddr = t_slot_q;
			ram_wdata = merged;
		end else if (cmd.walk && rd_pend_q) begin
			ram_we    = 1'b1;
		end
	end

	assign ram_raddr = cmd.walk ? dpos_inc : t_slot_q;

	tcw_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q     <= LAG_RESET;
			dpos_q    <= '0;
			clr_cnt_q <= '0;
			rd_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (lag_we) begin
				lag_q <= lag_wdata;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + SLOT_BITS'(1);
			end
			if (cmd.load) begin
				rd_pend_q <= 1'b0;
			end
			if (cmd.check && !stat.sched_ok) begin
				done_q <= 1'b1;
			end
			if (cmd.sched_wr) begin
				done_q <= 1'b1;
			end
			if (cmd.walk) begin
				if (dpos_q != end_q) begin
					dpos_q    <= dpos_inc;
					rd_pend_q <= 1'b1;
				end else begin
					rd_pend_q <= 1'b0;
				end
				if (stat.walk_done) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= item;
			end_q    <= item.now_tick[SLOT_BITS-1:0] - lag32[SLOT_BITS-1:0];
			latest_q <= '0;
			any_q    <= 1'b0;
		end
		if (cmd.calc) begin
			t_slot_q  <= t_max[SLOT_BITS-1:0];
			ahead_q   <= t_max - item_q.now_tick;
			lim_neg_q <= (lag32 > slots32);
			limit_q   <= LIM_W'(slots32 - lag32);
		end
		if (cmd.check && !stat.sched_ok) begin
			res_q.status    <= voice_bad ? ST_VOICE : ST_FAR;
			res_q.due_codes <= '0;
			res_q.any_due   <= 1'b0;
		end
		if (cmd.sched_wr) begin
			res_q.status    <= ST_OK;
			res_q.due_codes <= '0;
			res_q.any_due   <= 1'b0;
		end
		if (cmd.walk) begin
			if (dpos_q != end_q) begin
				pend_addr_q <= dpos_inc;
			end
			if (rd_pend_q) begin
				for (int v = 0; v < VOICES; v++) begin
					if (rdata[v*LANE_W +: LANE_W] != '0) begin
						latest_q[v*LANE_W +: LANE_W] <= rdata[v*LANE_W +: LANE_W];
						any_q <= 1'b1;
					end
				end
			end
			if (stat.walk_done) begin
				res_q.status    <= ST_OK;
				res_q.due_codes <= DUE_W'(latest_q);
				res_q.any_due   <= any_q;
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

/* sv/timed_command_wheel_top.sv */
// ----------------------------------------------------------------------------
// Timed command wheel
// Timing wheel of per-voice command bytes with schedule and drain commands.
//
//   port group            dir  handshake
//   item                  in   start & !busy
//   result                out  done, one cycle, no back-pressure
//   lag_we / lag_wdata    in   lag_we, single register
//
// Schedule: load, calc, check and write states in turn (no write when rejected),
// a slot read-modify-write through the single RAM read and write ports.
// Drain: n slots walked, n from 0 to SLOTS-1, one slot read and cleared per cycle;
// the walk ends when the drain pointer reaches the slot of now_tick minus the lag.
// Reset: a clearing pass zeroes all SLOTS slots of the RAM; busy stays high.
// The result is shown on one cycle of done; busy is low in that cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_command_wheel_top #(
	parameter int SLOT_BITS = 10,
	parameter int VOICES    = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  tcw_pkg::in_word_t         item,
	output logic                      done,
	output tcw_pkg::out_word_t        result,
	input  logic                      lag_we,
	input  logic [tcw_pkg::LAG_W-1:0] lag_wdata
);

	import tcw_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     res_empty;

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(item.command),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	tcw_dp #(
		.SLOT_BITS(SLOT_BITS),
		.VOICES   (VOICES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.lag_we   (lag_we),
		.lag_wdata(lag_wdata),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result),
		.done     (done)
	);

	assign res_empty = !result.any_due && (result.due_codes == '0);

`include "timed_command_wheel_top_assert.svh"

	`TCW_ASSERT_NEXT(a_single_strobe, done, !done)
	`TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`TCW_ASSERT_SAME(a_done_idle, done, !busy)
	`TCW_ASSERT_SAME(a_reject_empty, done && (result.status != ST_OK), res_empty)
	`TCW_ASSERT_SAME(a_none_due, done && !result.any_due, result.due_codes == '0)

endmodule
